// File: design/fspa_pkg.sv
// Shared types, register codes and status codes of the fixed slot pool allocator.
package fspa_pkg;

    // Build defaults
    localparam int unsigned MAX_SLOTS_DEF  = 64;
    localparam int unsigned ADDR_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int unsigned FIELD_ADDR_W = 32;
    localparam int unsigned SIZE_W       = 16;
    localparam int unsigned COUNT_W      = 7;
    localparam int unsigned PADDR_W      = 4;
    localparam int unsigned PDATA_W      = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_SIZE  = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    // Register reset values
    localparam logic [FIELD_ADDR_W-1:0] BASE_RST  = '0;
    localparam logic [SIZE_W-1:0]       SIZE_RST  = 16'd64;
    localparam logic [COUNT_W-1:0]      COUNT_RST = 7'd64;

    // Request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_FULL    = 2'd1;
    localparam t_status ST_INVALID = 2'd2;
    localparam t_status ST_DOUBLE  = 2'd3;

    typedef struct packed {
        logic                    operation;
        logic [FIELD_ADDR_W-1:0] free_address;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic [FIELD_ADDR_W-1:0] slot_address;
    } t_rsp;

    typedef struct packed {
        logic [FIELD_ADDR_W-1:0] region_base;
        logic [SIZE_W-1:0]       size_bytes;
        logic [COUNT_W-1:0]      num_slots;
    } t_cfg;

endpackage

// File: design/fixed_slot_pool_allocator.sv
// Fixed slot pool allocator: used-bit map in a row memory, read-modify-write per request.
// One request at a time, no stalls. Allocate: read and check one row (32 slots) after
// another; on a hit set its bit, then multiply index by size and add the base, else full.
// Free: limit, bound check, divider, row read and update; busy falls in the strobe cycle.
// Synchronous active-low reset clears control and registers, then a clearing pass
// zeroes the map one row a cycle (2^ROW_AW rows, 2 at 64 slots) with busy high.
module fixed_slot_pool_allocator #(
    parameter int unsigned MAX_SLOTS  = fspa_pkg::MAX_SLOTS_DEF,
    parameter int unsigned ADDR_WIDTH = fspa_pkg::ADDR_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  fspa_pkg::t_req               i_req,
    output logic                         o_done,
    output fspa_pkg::t_rsp               o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fspa_pkg::PADDR_W-1:0] paddr,
    input  logic [fspa_pkg::PDATA_W-1:0] pwdata,
    output logic [fspa_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import fspa_pkg::*;

    // Slot index = {row, column}
    localparam int unsigned IDX_W  = (MAX_SLOTS <= 4) ? 2 : $clog2(MAX_SLOTS);
    localparam int unsigned COL_W  = ((IDX_W - 1) < 5) ? (IDX_W - 1) : 5;
    localparam int unsigned ROW_AW = IDX_W - COL_W;
    localparam int unsigned ROW_W  = 1 << COL_W;
    localparam int unsigned ROWS   = 1 << ROW_AW;
    localparam int unsigned LIVE_W = IDX_W + 1;
    localparam int unsigned PROD_W = LIVE_W + SIZE_W;
    localparam int unsigned REM_W  = IDX_W + SIZE_W;
    localparam int unsigned CMP_W  = (ADDR_WIDTH > PROD_W) ? ADDR_WIDTH : PROD_W;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_A_RD  = 4'd2;
    localparam logic [3:0] S_A_CHK = 4'd3;
    localparam logic [3:0] S_A_MUL = 4'd4;
    localparam logic [3:0] S_A_ADD = 4'd5;
    localparam logic [3:0] S_F_LIM = 4'd6;
    localparam logic [3:0] S_F_CHK = 4'd7;
    localparam logic [3:0] S_F_DIV = 4'd8;
    localparam logic [3:0] S_F_RD  = 4'd9;
    localparam logic [3:0] S_F_UPD = 4'd10;

    t_cfg                  cfg;
    logic [3:0]            r_state, n_state;
    logic [ROW_AW-1:0]     r_row, n_row;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [ADDR_WIDTH-1:0] r_offset, n_offset;
    logic [PROD_W-1:0]     r_prod, n_prod;
    logic                  r_done, n_done;
    t_rsp                  r_rsp, n_rsp;

    logic [LIVE_W-1:0]     live;
    logic [LIVE_W-1:0]     mul_a;
    logic [ADDR_WIDTH-1:0] alloc_sum;
    logic                  hit;
    logic [COL_W-1:0]      hit_col;
    logic                  row_past_end;

    logic                  map_rd_en;
    logic [ROW_AW-1:0]     map_rd_addr;
    logic [ROW_W-1:0]      map_rd_data;
    logic                  map_wr_en;
    logic [ROW_AW-1:0]     map_wr_addr;
    logic [ROW_W-1:0]      map_wr_data;

    logic                  div_start;
    logic                  div_done;
    logic [IDX_W-1:0]      div_quot;
    logic                  div_rem_zero;

    fspa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fspa_map #(
        .ROW_AW (ROW_AW),
        .ROW_W  (ROW_W)
    ) u_map (
        .i_clk     (i_clk),
        .i_rd_en   (map_rd_en),
        .i_rd_addr (map_rd_addr),
        .o_rd_data (map_rd_data),
        .i_wr_en   (map_wr_en),
        .i_wr_addr (map_wr_addr),
        .i_wr_data (map_wr_data)
    );

    fspa_div #(
        .IDX_W (IDX_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (REM_W'(r_offset)),
        .i_divisor  (cfg.size_bytes),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem_zero (div_rem_zero)
    );

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // Clamp the slot count to the built capacity
    always_comb begin
        if (32'(cfg.num_slots) > 32'(MAX_SLOTS)) begin
            live = LIVE_W'(MAX_SLOTS);
        end else begin
            live = LIVE_W'(cfg.num_slots);
        end
    end

    // Shared multiplier: slot index for allocate, pool limit for free
    assign mul_a     = (r_state == S_F_LIM) ? live : LIVE_W'(r_idx);
    assign n_prod    = PROD_W'(mul_a) * PROD_W'(cfg.size_bytes);
    assign alloc_sum = ADDR_WIDTH'(cfg.region_base) + ADDR_WIDTH'(r_prod);

    // Find the lowest free live slot in the row just read
    assign row_past_end = (LIVE_W'({r_row, {COL_W{1'b0}}}) >= live);
    always_comb begin
        hit     = 1'b0;
        hit_col = '0;
        for (int c = ROW_W - 1; c >= 0; c--) begin
            if (!map_rd_data[c] && (LIVE_W'({r_row, COL_W'(c)}) < live)) begin
                hit     = 1'b1;
                hit_col = COL_W'(c);
            end
        end
    end

    // Request sequencer
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_idx       = r_idx;
        n_offset    = r_offset;
        n_done      = 1'b0;
        n_rsp       = r_rsp;
        div_start   = 1'b0;
        map_rd_en   = 1'b0;
        map_rd_addr = r_row;
        map_wr_en   = 1'b0;
        map_wr_addr = r_row;
        map_wr_data = '0;
        case (r_state)
            S_CLEAR: begin
                map_wr_en = 1'b1;
                n_row     = r_row + ROW_AW'(1);
                if (r_row == ROW_AW'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_row    = '0;
                    n_offset = ADDR_WIDTH'(i_req.free_address)
                             - ADDR_WIDTH'(cfg.region_base);
                    n_state  = (i_req.operation == OP_ALLOC) ? S_A_RD : S_F_LIM;
                end
            end
            S_A_RD: begin
                if (row_past_end) begin
                    n_done             = 1'b1;
                    n_rsp.status       = ST_FULL;
                    n_rsp.slot_address = '0;
                    n_state            = S_IDLE;
                end else begin
                    map_rd_en = 1'b1;
                    n_state   = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (hit) begin
                    map_wr_en   = 1'b1;
                    map_wr_data = map_rd_data | (ROW_W'(1) << hit_col);
                    n_idx       = {r_row, hit_col};
                    n_state     = S_A_MUL;
                end else if (r_row == ROW_AW'(ROWS - 1)) begin
                    n_done             = 1'b1;
                    n_rsp.status       = ST_FULL;
                    n_rsp.slot_address = '0;
                    n_state            = S_IDLE;
                end else begin
                    n_row   = r_row + ROW_AW'(1);
                    n_state = S_A_RD;
                end
            end
            S_A_MUL: begin
                n_state = S_A_ADD;
            end
            S_A_ADD: begin
                n_done             = 1'b1;
                n_rsp.status       = ST_OK;
                n_rsp.slot_address = FIELD_ADDR_W'(alloc_sum);
                n_state            = S_IDLE;
            end
            S_F_LIM: begin
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                // Offset must lie below count * size; a zero slot size fails here too
                if (CMP_W'(r_offset) < CMP_W'(r_prod)) begin
                    div_start = 1'b1;
                    n_state   = S_F_DIV;
                end else begin
                    n_done             = 1'b1;
                    n_rsp.status       = ST_INVALID;
                    n_rsp.slot_address = '0;
                    n_state            = S_IDLE;
                end
            end
            S_F_DIV: begin
                if (div_done) begin
                    if (div_rem_zero) begin
                        n_idx   = div_quot;
                        n_state = S_F_RD;
                    end else begin
                        n_done             = 1'b1;
                        n_rsp.status       = ST_INVALID;
                        n_rsp.slot_address = '0;
                        n_state            = S_IDLE;
                    end
                end
            end
            S_F_RD: begin
                map_rd_en   = 1'b1;
                map_rd_addr = r_idx[IDX_W-1 -: ROW_AW];
                n_state     = S_F_UPD;
            end
            S_F_UPD: begin
                n_done             = 1'b1;
                n_rsp.slot_address = '0;
                n_state            = S_IDLE;
                if (map_rd_data[r_idx[COL_W-1:0]]) begin
                    map_wr_en    = 1'b1;
                    map_wr_addr  = r_idx[IDX_W-1 -: ROW_AW];
                    map_wr_data  = map_rd_data & ~(ROW_W'(1) << r_idx[COL_W-1:0]);
                    n_rsp.status = ST_OK;
                end else begin
                    n_rsp.status = ST_DOUBLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_row   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_done  <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_offset <= n_offset;
        r_prod   <= n_prod;
        r_rsp    <= n_rsp;
    end

    // A result only follows work in progress
    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state != S_IDLE))
        else $error("result strobe without a request in progress");

    // Failed requests carry a zero address
    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status != ST_OK)) |-> (o_rsp.slot_address == '0))
        else $error("failed request returned a nonzero address");

    // The map is never written while idle
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !map_wr_en)
        else $error("map write while idle");

    // An accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

endmodule

// File: design/fspa_cfg.sv
// APB-style configuration registers of the pool allocator.
module fspa_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fspa_pkg::PADDR_W-1:0] paddr,
    input  logic [fspa_pkg::PDATA_W-1:0] pwdata,
    output logic [fspa_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output fspa_pkg::t_cfg               o_cfg
);
    import fspa_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Write on the access phase; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.region_base <= BASE_RST;
            r_cfg.size_bytes  <= SIZE_RST;
            r_cfg.num_slots   <= COUNT_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_BASE:  r_cfg.region_base <= pwdata;
                REG_SIZE:  r_cfg.size_bytes  <= pwdata[SIZE_W-1:0];
                REG_COUNT: r_cfg.num_slots   <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the selected register
    always_comb begin
        case (reg_sel)
            REG_BASE:  prdata = r_cfg.region_base;
            REG_SIZE:  prdata = PDATA_W'(r_cfg.size_bytes);
            REG_COUNT: prdata = PDATA_W'(r_cfg.num_slots);
            default:   prdata = '0;
        endcase
    end

endmodule

// File: design/fspa_map.sv
// Used-bit map memory: one write port, one registered read port.
module fspa_map #(
    parameter int unsigned ROW_AW = 1,
    parameter int unsigned ROW_W  = 32
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ROW_AW-1:0] i_rd_addr,
    output logic [ROW_W-1:0]  o_rd_data,
    input  logic              i_wr_en,
    input  logic [ROW_AW-1:0] i_wr_addr,
    input  logic [ROW_W-1:0]  i_wr_data
);
    localparam int unsigned ROWS = 1 << ROW_AW;

    logic [ROW_W-1:0] mem [ROWS];
    logic [ROW_W-1:0] r_rd_data;

    assign o_rd_data = r_rd_data;

    // Write one row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one row, forward a same-cycle write to the same row
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= mem[i_rd_addr];
            end
        end
    end

endmodule

// File: design/fspa_div.sv
// Restoring divider: one quotient bit per cycle, MSB first.
module fspa_div #(
    parameter int unsigned IDX_W = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [IDX_W+fspa_pkg::SIZE_W-1:0]   i_dividend,
    input  logic [fspa_pkg::SIZE_W-1:0]         i_divisor,
    output logic                                o_done,
    output logic [IDX_W-1:0]                    o_quot,
    output logic                                o_rem_zero
);
    import fspa_pkg::*;

    localparam int unsigned REM_W = IDX_W + SIZE_W;
    localparam int unsigned K_W   = $clog2(IDX_W + 1);

    logic             r_act;
    logic             r_done;
    logic [K_W-1:0]   r_cnt;
    logic [REM_W-1:0] r_rem;
    logic [REM_W-1:0] r_dsr;
    logic [IDX_W-1:0] r_quot;
    logic             fits;

    assign fits       = (r_rem >= r_dsr);
    assign o_done     = r_done;
    assign o_quot     = r_quot;
    assign o_rem_zero = (r_rem == '0);

    // Sequence the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_act <= 1'b1;
                r_cnt <= K_W'(IDX_W);
            end else if (r_act) begin
                r_cnt <= r_cnt - K_W'(1);
                if (r_cnt == K_W'(1)) begin
                    r_act  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Compare, subtract and shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_dsr  <= REM_W'(i_divisor) << (IDX_W - 1);
            r_quot <= '0;
        end else if (r_act) begin
            if (fits) begin
                r_rem <= r_rem - r_dsr;
            end
            r_dsr  <= r_dsr >> 1;
            r_quot <= {r_quot[IDX_W-2:0], fits};
        end
    end

endmodule

// File: bench/fixed_slot_pool_allocator_tb.sv
// Self-checking testbench for the fixed slot pool allocator: directed table, then random traffic.
module fixed_slot_pool_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fspa_pkg::*;

    // Index with no register behind it; writes there must have no effect
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int unsigned POOL_CAP = MAX_SLOTS_DEF;
    localparam int unsigned DIR_ROWS = 37;
    localparam int unsigned ITEMS_PER_SETTING = 50;
    localparam int unsigned TAIL_CYCLES = 30;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic        op;
        logic [31:0] data;
        logic [1:0]  reg_idx;
        bit          known;
        t_status     exp_status;
        logic [31:0] exp_addr;
    } t_row;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_done;
    t_rsp        o_rsp;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic        pready;

    // Shadow of the pool: register settings and one used bit per slot
    t_cfg             pool_cfg;
    logic [POOL_CAP-1:0] used_slots;
    t_rsp             rsp_expected[$];

    int unsigned n_errors = 0;
    int unsigned n_items = 0;
    int unsigned n_frees = 0;
    int unsigned n_settings = 0;
    int unsigned n_status[4] = '{0, 0, 0, 0};

    t_row dir_rows [DIR_ROWS] = '{
        // Defaults: base 0, size 64, count 64
        '{ROW_REQ, OP_ALLOC, 32'h0000_0000, REG_BASE, 1'b1, ST_OK, 32'h0000_0000},
        '{ROW_REQ, OP_ALLOC, 32'h0000_0000, REG_BASE, 1'b1, ST_OK, 32'h0000_0040},
        '{ROW_REQ, OP_FREE,  32'h0000_0000, REG_BASE, 1'b1, ST_OK, 32'h0000_0000},
        '{ROW_REQ, OP_FREE,  32'h0000_0000, REG_BASE, 1'b1, ST_DOUBLE, 32'h0000_0000},
        '{ROW_REQ, OP_FREE,  32'h0000_0020, REG_BASE, 1'b1, ST_INVALID, 32'h0000_0000},
        '{ROW_REQ, OP_FREE,  32'h0000_1000, REG_BASE, 1'b1, ST_INVALID, 32'h0000_0000},
        '{ROW_REQ, OP_FREE,  32'hFFFF_FFFF, REG_BASE, 1'b1, ST_INVALID, 32'h0000_0000},
        '{ROW_REQ, OP_ALLOC, 32'h0000_0000, REG_BASE, 1'b1, ST_OK, 32'h0000_0000},
        // Base near the top: slot addresses and free offsets wrap
        '{ROW_CFG, OP_ALLOC, 32'hFFFF_FFC0, REG_BASE, 1'b0, ST_OK, 32'h0},
        '{ROW_REQ, OP_ALLOC, 32'h0000_0000, REG_BASE, 1'b0, ST_OK, 32'h0},
        '{ROW_REQ, OP_FREE,  32'h0000_0040, REG_BASE, 1'b0, ST_OK, 32'h0},
        '{ROW_REQ, OP_FREE,  32'h0000_0000, REG_BASE, 1'b0, ST_OK, 32'h0},
        '{ROW_REQ, OP_FREE,  32'h0000_0010, REG_BASE, 1'b0, ST_OK, 32'h0},
        // Zero slots: allocate is full, free is invalid
        '{ROW_CFG, OP_ALLOC, 32'h0000_0000, REG_COUNT, 1'b0, ST_OK, 32'h0},
        '{ROW_REQ, OP_ALLOC, 32'h0000_0000, REG_BASE, 1'b1, ST_FULL, 32'h0000_0000},
        '{ROW_REQ, OP_FREE,  32'hFFFF_FFC0, REG_BASE, 1'b1, ST_INVALID, 32'h0000_0000},
        // Count above capacity clamps to the built size
        '{ROW_CFG, OP_ALLOC, 32'h0000_007F, REG_COUNT, 1'b0, ST_OK, 32'h0},
        '{ROW_REQ, OP_ALLOC, 32'h0000_0000, REG_BASE, 1'b0, ST_OK, 32'h0},
        // Zero slot size: every slot sits at base, every free is invalid
        '{ROW_CFG, OP_ALLOC, 32'h0000_0000, REG_SIZE, 1'b0, ST_OK, 32'h0},
        '{ROW_REQ, OP_ALLOC, 32'h0000_0000, REG_BASE, 1'b1, ST_OK, 32'hFFFF_FFC0},
        '{ROW_REQ, OP_FREE,  32'hFFFF_FFC0, REG_BASE, 1'b1, ST_INVALID, 32'h0000_0000},
        // Largest slot, two slots
        '{ROW_CFG, OP_ALLOC, 32'h0000_FFFF, REG_SIZE, 1'b0, ST_OK, 32'h0},
        '{ROW_CFG, OP_ALLOC, 32'h0000_0002, REG_COUNT, 1'b0, ST_OK, 32'h0},
        '{ROW_REQ, OP_ALLOC, 32'h0000_0000, REG_BASE, 1'b0, ST_OK, 32'h0},
        '{ROW_REQ, OP_ALLOC, 32'h0000_0000, REG_BASE, 1'b0, ST_OK, 32'h0},
        '{ROW_REQ, OP_FREE,  32'hFFFF_FFC0, REG_BASE, 1'b0, ST_OK, 32'h0},
        // Single one-byte slot at zero
        '{ROW_CFG, OP_ALLOC, 32'h0000_0000, REG_BASE, 1'b0, ST_OK, 32'h0},
        '{ROW_CFG, OP_ALLOC, 32'h0000_0001, REG_SIZE, 1'b0, ST_OK, 32'h0},
        '{ROW_CFG, OP_ALLOC, 32'h0000_0001, REG_COUNT, 1'b0, ST_OK, 32'h0},
        '{ROW_REQ, OP_FREE,  32'h0000_0000, REG_BASE, 1'b0, ST_OK, 32'h0},
        '{ROW_REQ, OP_ALLOC, 32'h0000_0000, REG_BASE, 1'b0, ST_OK, 32'h0},
        '{ROW_REQ, OP_ALLOC, 32'h0000_0000, REG_BASE, 1'b0, ST_OK, 32'h0},
        // Write to an unmapped index changes nothing
        '{ROW_CFG, OP_ALLOC, 32'hDEAD_BEEF, REG_UNUSED, 1'b0, ST_OK, 32'h0},
        '{ROW_REQ, OP_FREE,  32'h0000_0000, REG_BASE, 1'b0, ST_OK, 32'h0},
        '{ROW_REQ, OP_FREE,  32'h0000_0001, REG_BASE, 1'b0, ST_OK, 32'h0},
        '{ROW_CFG, OP_ALLOC, 32'h0000_0040, REG_COUNT, 1'b0, ST_OK, 32'h0},
        '{ROW_CFG, OP_ALLOC, 32'h0000_0040, REG_SIZE, 1'b0, ST_OK, 32'h0}
    };

    // Extreme settings opening each idling mode
    t_cfg edge_cfgs [3] = '{
        '{32'h0000_0000, 16'd1, 7'd1},
        '{32'hFFFF_FFFF, 16'hFFFF, 7'd64},
        '{32'h8000_0000, 16'd3, 7'd127}
    };

    int unsigned sender_pct [3] = '{8, 85, 0};

    fixed_slot_pool_allocator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int unsigned live_slots();
        return (pool_cfg.num_slots > POOL_CAP) ? POOL_CAP : pool_cfg.num_slots;
    endfunction

    // Compute the result of one request and advance the shadow used map
    function automatic t_rsp predict_rsp(t_req req);
        t_rsp        rsp;
        int unsigned live;
        bit          found;
        logic [31:0] offset;
        logic [31:0] index;
        rsp.status = ST_FULL;
        rsp.slot_address = '0;
        live = live_slots();
        found = 1'b0;
        if (req.operation == OP_ALLOC) begin
            for (int i = 0; i < live; i++) begin
                if (!found && !used_slots[i]) begin
                    found = 1'b1;
                    used_slots[i] = 1'b1;
                    rsp.status = ST_OK;
                    rsp.slot_address = pool_cfg.region_base + 32'(i) * 32'(pool_cfg.size_bytes);
                end
            end
        end else if (pool_cfg.size_bytes == '0) begin
            rsp.status = ST_INVALID;
        end else begin
            offset = req.free_address - pool_cfg.region_base;
            index = offset / 32'(pool_cfg.size_bytes);
            if (index >= live || offset % 32'(pool_cfg.size_bytes) != 0) begin
                rsp.status = ST_INVALID;
            end else if (!used_slots[index[5:0]]) begin
                rsp.status = ST_DOUBLE;
            end else begin
                used_slots[index[5:0]] = 1'b0;
                rsp.status = ST_OK;
            end
        end
        return rsp;
    endfunction

    // Random request: allocate or free, mostly at real slot addresses, some near misses and noise
    function automatic t_req make_req();
        t_req        req;
        int unsigned live;
        int unsigned pick;
        logic [31:0] slot_addr;
        live = live_slots();
        req.operation = ($urandom_range(1) == 0) ? OP_ALLOC : OP_FREE;
        req.free_address = $urandom;
        pick = $urandom_range(99);
        slot_addr = pool_cfg.region_base
                  + 32'($urandom_range(live == 0 ? 0 : live - 1)) * 32'(pool_cfg.size_bytes);
        if (pick < 55) begin
            req.free_address = slot_addr;
        end else if (pick < 70 && pool_cfg.size_bytes > 1) begin
            req.free_address = slot_addr + 32'($urandom_range(pool_cfg.size_bytes - 1, 1));
        end
        return req;
    endfunction

    function automatic t_cfg make_cfg();
        t_cfg c;
        c.region_base = $urandom;
        case ($urandom_range(7))
            0: c.region_base = 32'h0000_0000;
            1: c.region_base = 32'hFFFF_FFFF;
            default: ;
        endcase
        case ($urandom_range(9))
            0: c.size_bytes = 16'd1;
            1: c.size_bytes = 16'hFFFF;
            2: c.size_bytes = 16'd0;
            3, 4, 5: c.size_bytes = 16'($urandom_range(256, 1));
            default: c.size_bytes = 16'($urandom_range(65535, 1));
        endcase
        case ($urandom_range(9))
            0: c.num_slots = 7'd64;
            1: c.num_slots = 7'd127;
            2: c.num_slots = 7'($urandom_range(127));
            default: c.num_slots = 7'($urandom_range(8, 1));
        endcase
        return c;
    endfunction

    // Geometric idle run: each cycle idles with the given percent chance
    function automatic int unsigned pick_gap(int unsigned pct);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < pct && gap < 60) gap++;
        return gap;
    endfunction

    // Hold start low, then wait out every outstanding result
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (rsp_expected.size() != 0) @(posedge i_clk);
    endtask

    // Issue one request and record what it must return
    task automatic send_req(t_req req, int unsigned gap, bit known, t_rsp known_rsp);
        t_rsp pred;
        if (gap != 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = predict_rsp(req);
        rsp_expected.push_back(known ? known_rsp : pred);
        n_items++;
        if (req.operation == OP_FREE) n_frees++;
    endtask

    // APB write, then read back known registers
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        logic [31:0] want;
        bit          mapped;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        mapped = 1'b1;
        want = '0;
        case (idx)
            REG_BASE: begin
                pool_cfg.region_base = value;
                want = value;
            end
            REG_SIZE: begin
                pool_cfg.size_bytes = value[SIZE_W-1:0];
                want = 32'(pool_cfg.size_bytes);
            end
            REG_COUNT: begin
                pool_cfg.num_slots = value[COUNT_W-1:0];
                want = 32'(pool_cfg.num_slots);
            end
            default: mapped = 1'b0;
        endcase
        n_settings++;
        @(negedge i_clk);
        if (mapped) begin
            penable <= 1'b0;
            pwrite <= 1'b0;
            @(negedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (pready !== 1'b1);
            if (prdata !== want) begin
                n_errors++;
                $display("%0t: register %0d readback mismatch: expected %h, got %h",
                         $time, idx, want, prdata);
            end
            @(negedge i_clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apply_cfg(t_cfg c);
        write_reg(REG_BASE, c.region_base);
        write_reg(REG_SIZE, 32'(c.size_bytes));
        write_reg(REG_COUNT, 32'(c.num_slots));
    endtask

    // Match each result strobe against the oldest expectation
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done !== 1'b0) begin
            if (rsp_expected.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result: status %0d address %h",
                         $time, o_rsp.status, o_rsp.slot_address);
            end else begin
                want = rsp_expected.pop_front();
                n_status[want.status]++;
                if (o_rsp.status !== want.status) begin
                    n_errors++;
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, o_rsp.status);
                end
                if (o_rsp.slot_address !== want.slot_address) begin
                    n_errors++;
                    $display("%0t: slot address mismatch: expected %h, got %h",
                             $time, want.slot_address, o_rsp.slot_address);
                end
            end
        end
    end

    // Main sequence
    initial begin
        t_req req;
        t_rsp typed;
        t_cfg setting;
        pool_cfg = '{BASE_RST, SIZE_RST, COUNT_RST};
        used_slots = '0;

        // Hold reset, then release it on a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                drain_results();
                write_reg(dir_rows[r].reg_idx, dir_rows[r].data);
            end else begin
                req.operation = dir_rows[r].op;
                req.free_address = dir_rows[r].data;
                typed.status = dir_rows[r].exp_status;
                typed.slot_address = dir_rows[r].exp_addr;
                send_req(req, pick_gap(sender_pct[0]), dir_rows[r].known, typed);
            end
        end

        // Random traffic: three idling modes, three settings each
        for (int mode = 0; mode < 3; mode++) begin
            for (int sub = 0; sub < 3; sub++) begin
                drain_results();
                setting = (sub == 0) ? edge_cfgs[mode] : make_cfg();
                apply_cfg(setting);
                for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                    if ($urandom_range(99) < 2) drain_results();
                    typed = '0;
                    send_req(make_req(), pick_gap(sender_pct[mode]), 1'b0, typed);
                end
            end
        end

        // Wait for the last results, then let the block settle
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (rsp_expected.size() != 0) n_errors++;

        $display("Covered %0d requests (%0d frees) over %0d register writes",
                 n_items, n_frees, n_settings);
        $display("Sender idle 8/85/0 pct; ok %0d, full %0d, invalid %0d, double free %0d",
                 n_status[ST_OK], n_status[ST_FULL], n_status[ST_INVALID], n_status[ST_DOUBLE]);
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/fspa_pkg.sv
design/fspa_cfg.sv
design/fspa_map.sv
design/fspa_div.sv
design/fixed_slot_pool_allocator.sv
bench/fixed_slot_pool_allocator_tb.sv
